FILE: hw/rtl/pwl_pkg.sv
// shared constants, codes and control types of the waveform player
// used by every module of the block but pwl_ram; no dependencies
package pwl_pkg;

	localparam int MAX_POINTS = 64;
	localparam int TIME_BITS  = 32;
	localparam int LEVEL_BITS = 16;

	// fixed field widths
	localparam int SLOT_W  = 6;
	localparam int PHASE_W = 32;
	localparam int REP_W   = 17;
	localparam int PTS_W   = 7;
	localparam int IN_DATA_W = 88;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int RAM_W  = TIME_BITS + LEVEL_BITS;
	localparam int PROD_W = TIME_BITS + LEVEL_BITS;
	localparam int DIV_W  = (PROD_W > PHASE_W) ? PROD_W : PHASE_W;
	localparam int DCNT_W = $clog2(DIV_W);

	localparam int WALK_CAP = 3 * MAX_POINTS + 8;
	localparam int ITER_W   = $clog2(WALK_CAP + 1);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} pwl_op_t;

	typedef enum logic [1:0] {
		REG_PHASE  = 2'd0,
		REG_REPEAT = 2'd1,
		REG_POINTS = 2'd2
	} pwl_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ST_RD, S_ST_PER, S_ST_DIV1, S_ST_DIV2,
		S_RD1, S_L1, S_CHK, S_L2, S_CMP, S_ISTART, S_IWAIT,
		S_KDIV, S_KMUL, S_WRAP, S_OUT
	} pwl_state_t;

	typedef enum logic [1:0] {ADDR_IDX, ADDR_NEXT, ADDR_LAST} pwl_addr_t;
	typedef enum logic [2:0] {ORG_HOLD, ORG_SAMP, ORG_PHASE, ORG_ALIGN, ORG_WRAP} pwl_org_t;
	typedef enum logic [2:0] {DIV_NONE, DIV_PER, DIV_PHASE, DIV_K, DIV_INTERP} pwl_div_t;
	typedef enum logic {RES_V1, RES_INTERP} pwl_res_t;

	typedef struct packed {
		logic      tbl_wr;
		logic      start_init;
		logic      samp_ld;
		logic      s_init;
		logic      t1_ld;
		logic      t2_ld;
		logic      adv;
		logic      rl_hold;
		logic      tmp_ld;
		logic      k_ld;
		logic      kmul;
		logic      wrap;
		logic      imul;
		logic      res_ld;
		logic      out_ld;
		pwl_res_t  res_src;
		pwl_addr_t addr_sel;
		pwl_org_t  org_sel;
		pwl_div_t  div_sel;
	} pwl_cmd_t;

	typedef struct packed {
		logic phase_neg;
		logic rl_one;
		logic per_zero;
		logic div_done;
		logic cap;
		logic last;
		logic rep_ok;
		logic t1_zero;
		logic s_ge_t2;
		logic s_lt_t1;
		logic out_free;
	} pwl_stat_t;

endpackage

FILE: hw/rtl/pwl_ram.sv
// generic single write port / single read port ram with registered read
// no dependencies
module pwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/pwl_div.sv
// restoring divider, one quotient bit per cycle
// depends on pwl_pkg
module pwl_div import pwl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [TIME_BITS-1:0] divisor,
	output logic                 done,
	output logic [DIV_W-1:0]     quo,
	output logic [TIME_BITS-1:0] rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DCNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] dvs_q;
	logic [TIME_BITS:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? TIME_BITS'(trial - {1'b0, dvs_q}) : trial[TIME_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: hw/rtl/pwl_dp.sv
// datapath: point table, playback state, divider, interpolation and output register
// depends on pwl_pkg, pwl_ram, pwl_div
module pwl_dp import pwl_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pwl_cmd_t                     cmd,
	output pwl_stat_t                    st,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [PHASE_W-1:0]           cfg_data,
	input  logic [SLOT_W-1:0]            in_slot,
	input  logic [TIME_BITS-1:0]         in_time,
	input  logic [LEVEL_BITS-1:0]        in_level,
	input  logic [TIME_BITS-1:0]         in_sample,
	input  logic                         m_ready,
	output logic                         m_valid,
	output logic [LEVEL_BITS-1:0]        m_level
);

	logic [PHASE_W-1:0]           phase_q;
	logic signed [REP_W-1:0]      rep_q;
	logic [PTS_W-1:0]             pts_q;
	logic signed [REP_W-1:0]      rl_q;
	logic [IDX_W-1:0]             idx_q;
	logic [TIME_BITS-1:0]         origin_q;
	logic [ITER_W-1:0]            iter_q;
	logic                         mval_q;

	logic [TIME_BITS-1:0]         samp_q, s_q, tmp_q, t1_q, t2_q, k_q, kt_q;
	logic signed [LEVEL_BITS-1:0] v1_q, v2_q, res_q;
	logic [LEVEL_BITS-1:0]        mlev_q;
	logic [DIV_W-1:0]             prod_q;
	logic                         neg_q;

	logic [CNT_W-1:0]             n_pts, nxt;
	logic [IDX_W-1:0]             last_idx, raddr;
	logic                         ram_we;
	logic [RAM_W-1:0]             rdata;
	logic [TIME_BITS-1:0]         rd_time;
	logic [LEVEL_BITS-1:0]        rd_level;

	logic                         div_start, div_done;
	logic [DIV_W-1:0]             dvd, div_quo;
	logic [TIME_BITS-1:0]         dvs, div_rem;

	logic signed [LEVEL_BITS:0]   diff, mag;
	logic [TIME_BITS-1:0]         ds;
	logic [PROD_W-1:0]            iprod;
	logic [LEVEL_BITS-1:0]        q_l;
	logic signed [LEVEL_BITS-1:0] ires;

	logic [TIME_BITS-1:0]         k_raw, k0, kc;
	logic [REP_W-1:0]             rl_m1;
	logic                         rl_pos, clip;
	logic [2*TIME_BITS-1:0]       kprod;

	// points in use clamped to 1..MAX_POINTS
	always_comb begin
		if (pts_q == '0) begin
			n_pts = CNT_W'(1);
		end else if (int'(pts_q) > MAX_POINTS) begin
			n_pts = CNT_W'(MAX_POINTS);
		end else begin
			n_pts = CNT_W'(pts_q);
		end
	end

	assign last_idx = IDX_W'(n_pts - CNT_W'(1));
	assign nxt      = CNT_W'(idx_q) + CNT_W'(1);

	always_comb begin
		case (cmd.addr_sel)
			ADDR_NEXT: raddr = idx_q + 1'b1;
			ADDR_LAST: raddr = last_idx;
			default:   raddr = idx_q;
		endcase
	end

	assign ram_we = cmd.tbl_wr && (int'(in_slot) < MAX_POINTS);

	pwl_ram #(.WIDTH(RAM_W), .DEPTH(MAX_POINTS)) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(in_slot)),
		.wdata ({in_time, in_level}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_time  = rdata[RAM_W-1:LEVEL_BITS];
	assign rd_level = rdata[LEVEL_BITS-1:0];

	always_comb begin
		case (cmd.div_sel)
			DIV_PER: begin
				dvd = DIV_W'(samp_q);
				dvs = rd_time;
			end
			DIV_PHASE: begin
				dvd = DIV_W'(phase_q);
				dvs = t1_q;
			end
			DIV_K: begin
				dvd = DIV_W'(s_q);
				dvs = t1_q;
			end
			DIV_INTERP: begin
				dvd = prod_q;
				dvs = t2_q - t1_q;
			end
			default: begin
				dvd = '0;
				dvs = t1_q;
			end
		endcase
	end

	assign div_start = cmd.div_sel != DIV_NONE;

	pwl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// interpolation: |v2 - v1| * (s - t1), sign kept apart
	assign diff  = {v2_q[LEVEL_BITS-1], v2_q} - {v1_q[LEVEL_BITS-1], v1_q};
	assign mag   = diff[LEVEL_BITS] ? -diff : diff;
	assign ds    = s_q - t1_q;
	assign iprod = PROD_W'(mag[LEVEL_BITS-1:0]) * PROD_W'(ds);
	assign q_l   = div_quo[LEVEL_BITS-1:0];
	assign ires  = neg_q ? v1_q - $signed(q_l) : v1_q + $signed(q_l);

	// wrap count, at least one, limited by the repeat budget
	assign k_raw  = div_quo[TIME_BITS-1:0];
	assign k0     = (k_raw == '0) ? TIME_BITS'(1) : k_raw;
	assign rl_pos = !rl_q[REP_W-1] && (rl_q != '0);
	assign rl_m1  = rl_q - REP_W'(1);
	assign clip   = rl_pos && ((TIME_BITS + REP_W)'(k0) > (TIME_BITS + REP_W)'(rl_m1));
	assign kc     = clip ? TIME_BITS'(rl_m1) : k0;
	assign kprod  = (2*TIME_BITS)'(k_q) * (2*TIME_BITS)'(t1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '1;
			rep_q    <= REP_W'(1);
			pts_q    <= PTS_W'(1);
			rl_q     <= REP_W'(1);
			idx_q    <= '0;
			origin_q <= '0;
			iter_q   <= '0;
			mval_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (pwl_reg_t'(cfg_index))
					REG_PHASE:  phase_q <= cfg_data;
					REG_REPEAT: rep_q   <= cfg_data[REP_W-1:0];
					REG_POINTS: pts_q   <= cfg_data[PTS_W-1:0];
					default: ;
				endcase
			end

			if (cmd.start_init) begin
				rl_q <= (rep_q == '0) ? REP_W'(1) : rep_q;
			end else if (cmd.rl_hold && rl_pos) begin
				rl_q <= REP_W'(1);
			end else if (cmd.k_ld && rl_pos) begin
				rl_q <= rl_q - $signed(kc[REP_W-1:0]);
			end

			if (cmd.start_init || cmd.wrap) begin
				idx_q <= '0;
			end else if (cmd.adv) begin
				idx_q <= idx_q + 1'b1;
			end

			case (cmd.org_sel)
				ORG_SAMP:  origin_q <= samp_q;
				ORG_PHASE: origin_q <= phase_q[TIME_BITS-1:0];
				ORG_ALIGN: origin_q <= tmp_q + div_rem;
				ORG_WRAP:  origin_q <= origin_q + kt_q;
				default: ;
			endcase

			if (cmd.s_init) begin
				iter_q <= '0;
			end else if (cmd.adv || cmd.wrap) begin
				iter_q <= iter_q + 1'b1;
			end

			if (cmd.out_ld) begin
				mval_q <= 1'b1;
			end else if (m_ready) begin
				mval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.samp_ld) begin
			samp_q <= in_sample;
		end
		if (cmd.s_init) begin
			s_q <= (in_sample < origin_q) ? '0 : in_sample - origin_q;
		end else if (cmd.wrap) begin
			s_q <= s_q - kt_q;
		end
		if (cmd.tmp_ld) begin
			tmp_q <= samp_q - div_rem;
		end
		if (cmd.t1_ld) begin
			t1_q <= rd_time;
			v1_q <= rd_level;
		end else if (cmd.adv) begin
			t1_q <= t2_q;
			v1_q <= v2_q;
		end else if (cmd.div_sel == DIV_PER) begin
			t1_q <= rd_time;
		end
		if (cmd.t2_ld) begin
			t2_q <= rd_time;
			v2_q <= rd_level;
		end
		if (cmd.k_ld) begin
			k_q <= kc;
		end
		if (cmd.kmul) begin
			kt_q <= kprod[TIME_BITS-1:0];
		end
		if (cmd.imul) begin
			prod_q <= DIV_W'(iprod);
			neg_q  <= diff[LEVEL_BITS];
		end
		if (cmd.res_ld) begin
			res_q <= (cmd.res_src == RES_INTERP) ? ires : v1_q;
		end
		if (cmd.out_ld) begin
			mlev_q <= res_q;
		end
	end

	always_comb begin
		st.phase_neg = phase_q[PHASE_W-1];
		st.rl_one    = rl_q == REP_W'(1);
		st.per_zero  = rd_time == '0;
		st.div_done  = div_done;
		st.cap       = iter_q >= ITER_W'(WALK_CAP);
		st.last      = nxt >= n_pts;
		st.rep_ok    = (rl_q > 17'sd1) || (rl_q == -17'sd1);
		st.t1_zero   = t1_q == '0;
		st.s_ge_t2   = s_q >= t2_q;
		st.s_lt_t1   = s_q < t1_q;
		st.out_free  = !mval_q || m_ready;
	end

	assign m_valid = mval_q;
	assign m_level = mlev_q;

endmodule

FILE: hw/rtl/pwl_ctrl.sv
// controller state machine: sequences start alignment and the point walk
// depends on pwl_pkg
module pwl_ctrl import pwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  pwl_op_t   op,
	input  pwl_stat_t st,
	output logic      in_ready,
	output pwl_cmd_t  cmd
);

	pwl_state_t state_q, state_d;
	logic       accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_START:  state_d = S_ST_RD;
						OP_SAMPLE: state_d = S_RD1;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ST_RD: begin
				if (st.phase_neg || st.rl_one) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_ST_PER;
				end
			end
			S_ST_PER:  state_d = st.per_zero ? S_IDLE : S_ST_DIV1;
			S_ST_DIV1: if (st.div_done) state_d = S_ST_DIV2;
			S_ST_DIV2: if (st.div_done) state_d = S_IDLE;
			S_RD1:     state_d = S_L1;
			S_L1:      state_d = S_CHK;
			S_CHK: begin
				if (st.cap) begin
					state_d = S_OUT;
				end else if (st.last) begin
					state_d = (st.rep_ok && !st.t1_zero) ? S_KDIV : S_OUT;
				end else begin
					state_d = S_L2;
				end
			end
			S_L2:  state_d = S_CMP;
			S_CMP: begin
				if (st.s_ge_t2) begin
					state_d = S_CHK;
				end else if (st.s_lt_t1) begin
					state_d = S_OUT;
				end else begin
					state_d = S_ISTART;
				end
			end
			S_ISTART: state_d = S_IWAIT;
			S_IWAIT:  if (st.div_done) state_d = S_OUT;
			S_KDIV:   if (st.div_done) state_d = S_KMUL;
			S_KMUL:   state_d = S_WRAP;
			S_WRAP:   state_d = S_RD1;
			S_OUT:    if (st.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.res_src  = RES_V1;
		cmd.addr_sel = ADDR_IDX;
		cmd.org_sel  = ORG_HOLD;
		cmd.div_sel  = DIV_NONE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_LOAD:  cmd.tbl_wr = 1'b1;
						OP_START: begin
							cmd.start_init = 1'b1;
							cmd.samp_ld    = 1'b1;
						end
						OP_SAMPLE: cmd.s_init = 1'b1;
						default: ;
					endcase
				end
			end
			S_ST_RD: begin
				if (st.phase_neg) begin
					cmd.org_sel = ORG_SAMP;
				end else if (st.rl_one) begin
					cmd.org_sel = ORG_PHASE;
				end else begin
					cmd.addr_sel = ADDR_LAST;
				end
			end
			S_ST_PER: begin
				if (st.per_zero) begin
					cmd.org_sel = ORG_SAMP;
				end else begin
					cmd.div_sel = DIV_PER;
				end
			end
			S_ST_DIV1: begin
				if (st.div_done) begin
					cmd.tmp_ld  = 1'b1;
					cmd.div_sel = DIV_PHASE;
				end
			end
			S_ST_DIV2: if (st.div_done) cmd.org_sel = ORG_ALIGN;
			S_RD1:     cmd.addr_sel = ADDR_IDX;
			S_L1:      cmd.t1_ld = 1'b1;
			S_CHK: begin
				if (st.cap) begin
					cmd.res_ld = 1'b1;
				end else if (st.last) begin
					if (!st.rep_ok) begin
						cmd.res_ld = 1'b1;
					end else if (st.t1_zero) begin
						cmd.rl_hold = 1'b1;
						cmd.res_ld  = 1'b1;
					end else begin
						cmd.div_sel = DIV_K;
					end
				end else begin
					cmd.addr_sel = ADDR_NEXT;
				end
			end
			S_L2: cmd.t2_ld = 1'b1;
			S_CMP: begin
				if (st.s_ge_t2) begin
					cmd.adv = 1'b1;
				end else if (st.s_lt_t1) begin
					cmd.res_ld = 1'b1;
				end else begin
					cmd.imul = 1'b1;
				end
			end
			S_ISTART: cmd.div_sel = DIV_INTERP;
			S_IWAIT: begin
				if (st.div_done) begin
					cmd.res_ld  = 1'b1;
					cmd.res_src = RES_INTERP;
				end
			end
			S_KDIV: if (st.div_done) cmd.k_ld = 1'b1;
			S_KMUL: cmd.kmul = 1'b1;
			S_WRAP: begin
				cmd.wrap    = 1'b1;
				cmd.org_sel = ORG_WRAP;
			end
			S_OUT: if (st.out_free) cmd.out_ld = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/piecewise_linear_waveform_player_unit.sv
// top level of the piecewise linear waveform player
// depends on pwl_pkg, pwl_ctrl, pwl_dp (and through it pwl_ram, pwl_div)
//
// usage:
//  - input stream (s_*): one word per command; s_tuser carries the operation
//    (load point, start playback, request sample). load and start give no
//    output word, a sample request gives exactly one word on m_*
//  - output stream (m_*): interpolated level, signed q3.12, held in an output
//    register until m_tready takes it; a new command is accepted meanwhile
//  - config port: cfg_we writes cfg_data into register cfg_index
//    (0 start phase, 1 repeat setting, 2 points in use); write only when idle
//  - timing: a load is taken without leaving idle. a start returns to idle after
//    its config or period check, or runs two serial divides to align to the period.
//    a request fetches its first point, walks the points one by one, runs a
//    serial divide when it interpolates and a divide and a multiply for each
//    wrap, then loads the output register; the serial divider and the single
//    table read port set the pace of these steps
//  - reset: clears the walk index, origin and output valid; config registers
//    return to phase -1, repeat 1, points 1; point table contents are undefined
//  - output stall: a finished result waits in the last state until the output
//    register is free, and no new command is accepted until then
module piecewise_linear_waveform_player_unit import pwl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // point_slot, point_time, point_level, sample_number
	input  logic [1:0]            s_tuser,  // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [LEVEL_BITS-1:0] m_tdata,  // level_out
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [PHASE_W-1:0]    cfg_data
);

	// input word field boundaries
	localparam int TIME_LO   = SLOT_W;
	localparam int LEVEL_LO  = TIME_LO + TIME_BITS;
	localparam int SAMPLE_LO = LEVEL_LO + LEVEL_BITS;

	pwl_cmd_t  cmd;
	pwl_stat_t st;

	// controller sequences the work, datapath holds tables and arithmetic
	pwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.op       (pwl_op_t'(s_tuser)),
		.st       (st),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	pwl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_slot   (s_tdata[SLOT_W-1:0]),
		.in_time   (s_tdata[LEVEL_LO-1:TIME_LO]),
		.in_level  (s_tdata[SAMPLE_LO-1:LEVEL_LO]),
		.in_sample (s_tdata[SAMPLE_LO+TIME_BITS-1:SAMPLE_LO]),
		.m_ready   (m_tready),
		.m_valid   (m_tvalid),
		.m_level   (m_tdata)
	);

endmodule

FILE: hw/rtl/pwl_chk.sv
// port level checks of the waveform player, bound to the top level
// depends on pwl_pkg
module pwl_chk import pwl_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [LEVEL_BITS-1:0] m_tdata
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// sample request keeps the block busy
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_SAMPLE) |=> !s_tready)
		else $error("ready right after sample request");

	// loads and unused ops leave the input ready in the next cycle
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ((s_tuser == OP_LOAD) || (s_tuser == OP_NONE)) |=> s_tready)
		else $error("load or unused op stalled input");

	// a new result only comes out of a busy block
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without pending request");

endmodule

bind piecewise_linear_waveform_player_unit pwl_chk u_chk (.*);
